@@ rtl/core/header_field_stream_parser_assert.svh @@
// Assertion macros for the checker of the header field stream parser.
`ifndef HEADER_FIELD_STREAM_PARSER_ASSERT_SVH
`define HEADER_FIELD_STREAM_PARSER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define HFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after reset is seen.
`define HFP_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hfp_pkg.sv @@
package hfp_pkg;

  localparam int SPACE_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] PH_LINE  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  localparam logic [2:0] K_KEY   = 3'd0;
  localparam logic [2:0] K_VALUE = 3'd1;
  localparam logic [2:0] K_PAIR  = 3'd2;
  localparam logic [2:0] K_END   = 3'd3;
  localparam logic [2:0] K_ERR   = 3'd4;

  localparam logic FK_KEY   = 1'b0;
  localparam logic FK_VALUE = 1'b1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Work for the back end, carried out in field order from top to bottom.
  typedef struct packed {
    logic       pair;
    logic       clear;
    logic       flush;
    logic       fkind;
    logic       e1;
    logic       k1;
    logic [7:0] b1;
    logic       e2;
    logic       k2;
    logic [7:0] b2;
    logic       hold;
    logic       hend;
    logic       err;
  } hfp_rec_t;

endpackage

@@ rtl/core/hfp_in_if.sv @@
interface hfp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_in;

  modport source (output valid, output op, output byte_in, input ready);
  modport sink (input valid, input op, input byte_in, output ready);
endinterface

@@ rtl/core/hfp_out_if.sv @@
interface hfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_out;
  logic       last;

  modport source (output valid, output kind, output byte_out, output last, input ready);
  modport sink (input valid, input kind, input byte_out, input last, output ready);
endinterface

@@ rtl/core/hfp_front.sv @@
module hfp_front import hfp_pkg::*; #(
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  hfp_in_if.sink   hdr,
  output hfp_rec_t rec,
  output logic     push,
  input  logic     full
);

  localparam int CW = $clog2(SPACE_DEPTH + 1);

  logic [1:0]    phase;
  logic          cr_held;
  logic          pair_open;
  logic          field_started;
  logic [CW-1:0] space_count;

  logic [1:0]    phase_next;
  logic          cr_held_next;
  logic          pair_open_next;
  logic          field_started_next;
  logic [CW-1:0] space_count_next;

  logic          accept;
  logic          take_b;
  logic          ws;
  logic [7:0]    b;

  assign hdr.ready = !full;
  assign accept = hdr.valid && hdr.ready;
  assign push = accept && (|rec);
  assign b = hdr.byte_in;
  assign ws = (b == CH_SP) || (b == CH_TAB);

  always_comb begin
    rec = '0;
    phase_next = phase;
    cr_held_next = cr_held;
    pair_open_next = pair_open;
    field_started_next = field_started;
    space_count_next = space_count;
    take_b = 1'b0;

    if (hdr.op) begin
      rec.clear = (space_count != '0);
      phase_next = PH_LINE;
      cr_held_next = 1'b0;
      pair_open_next = 1'b0;
      field_started_next = 1'b0;
      space_count_next = '0;
    end else if (phase != PH_STOP) begin
      take_b = 1'b1;
      if (cr_held) begin
        cr_held_next = 1'b0;
        if (b == CH_LF) begin
          take_b = 1'b0;
          case (phase)
            PH_LINE: begin
              rec.pair = pair_open;
              rec.hend = 1'b1;
              rec.clear = (space_count != '0);
              pair_open_next = 1'b0;
              field_started_next = 1'b0;
              space_count_next = '0;
              phase_next = PH_STOP;
            end
            PH_KEY: begin
              rec.err = 1'b1;
              phase_next = PH_STOP;
            end
            PH_VALUE: begin
              phase_next = PH_LINE;
            end
            default: begin
            end
          endcase
        end else begin
          // The held CR turns out to be data.
          rec.e1 = 1'b1;
          rec.b1 = CH_CR;
          case (phase)
            PH_LINE: begin
              rec.pair = pair_open;
              rec.clear = (space_count != '0);
              pair_open_next = 1'b0;
              field_started_next = 1'b0;
              phase_next = PH_KEY;
              rec.k1 = FK_KEY;
            end
            PH_KEY: begin
              rec.flush = (space_count != '0);
              rec.fkind = FK_KEY;
              rec.k1 = FK_KEY;
            end
            default: begin
              rec.flush = (space_count != '0);
              rec.fkind = FK_VALUE;
              rec.k1 = FK_VALUE;
              field_started_next = 1'b1;
            end
          endcase
          space_count_next = '0;
        end
      end

      if (take_b) begin
        if (b == CH_CR) begin
          if (((phase_next == PH_KEY) || (phase_next == PH_VALUE)) &&
              (space_count_next >= CW'(SPACE_DEPTH))) begin
            rec.err = 1'b1;
            phase_next = PH_STOP;
            cr_held_next = 1'b0;
          end else begin
            cr_held_next = 1'b1;
          end
        end else begin
          case (phase_next)
            PH_LINE: begin
              if (ws) begin
                if (!pair_open_next) begin
                  rec.err = 1'b1;
                  phase_next = PH_STOP;
                  cr_held_next = 1'b0;
                end else begin
                  phase_next = PH_VALUE;
                end
              end else begin
                rec.pair = pair_open_next;
                pair_open_next = 1'b0;
                if (space_count_next != '0) begin
                  rec.clear = 1'b1;
                end
                space_count_next = '0;
                field_started_next = 1'b0;
                if (b == CH_COLON) begin
                  rec.err = 1'b1;
                  phase_next = PH_STOP;
                  cr_held_next = 1'b0;
                end else begin
                  phase_next = PH_KEY;
                  rec.e2 = 1'b1;
                  rec.k2 = FK_KEY;
                  rec.b2 = b;
                end
              end
            end
            PH_KEY: begin
              if (b == CH_COLON) begin
                if (space_count_next != '0) begin
                  rec.clear = 1'b1;
                end
                space_count_next = '0;
                field_started_next = 1'b0;
                pair_open_next = 1'b1;
                phase_next = PH_VALUE;
              end else if (ws) begin
                if (space_count_next >= CW'(SPACE_DEPTH)) begin
                  rec.err = 1'b1;
                  phase_next = PH_STOP;
                  cr_held_next = 1'b0;
                end else begin
                  rec.hold = 1'b1;
                  rec.b2 = b;
                  space_count_next = space_count_next + CW'(1);
                end
              end else begin
                if (space_count_next != '0) begin
                  rec.flush = 1'b1;
                  rec.fkind = FK_KEY;
                end
                space_count_next = '0;
                rec.e2 = 1'b1;
                rec.k2 = FK_KEY;
                rec.b2 = b;
              end
            end
            PH_VALUE: begin
              if (ws) begin
                if (field_started_next) begin
                  if (space_count_next >= CW'(SPACE_DEPTH)) begin
                    rec.err = 1'b1;
                    phase_next = PH_STOP;
                    cr_held_next = 1'b0;
                  end else begin
                    rec.hold = 1'b1;
                    rec.b2 = b;
                    space_count_next = space_count_next + CW'(1);
                  end
                end
              end else begin
                if (space_count_next != '0) begin
                  rec.flush = 1'b1;
                  rec.fkind = FK_VALUE;
                end
                space_count_next = '0;
                rec.e2 = 1'b1;
                rec.k2 = FK_VALUE;
                rec.b2 = b;
                field_started_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LINE;
      cr_held <= 1'b0;
      pair_open <= 1'b0;
      field_started <= 1'b0;
      space_count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      cr_held <= cr_held_next;
      pair_open <= pair_open_next;
      field_started <= field_started_next;
      space_count <= space_count_next;
    end
  end

endmodule

@@ rtl/core/hfp_queue.sv @@
module hfp_queue import hfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  hfp_rec_t wdata,
  output logic     full,
  input  logic     pop,
  output hfp_rec_t rdata,
  output logic     avail
);

  hfp_rec_t          slots [QUEUE_DEPTH];
  logic [QPW-1:0]    wptr;
  logic [QPW-1:0]    rptr;
  logic [QPW:0]      count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == (QPW + 1)'(QUEUE_DEPTH));
  assign avail = (count != '0);
  assign rdata = slots[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + QPW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + QPW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPW + 1)'(1);
        2'b01:   count <= count - (QPW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/hfp_back.sv @@
module hfp_back import hfp_pkg::*; #(
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  hfp_rec_t rec,
  input  logic     avail,
  output logic     pop,
  hfp_out_if.source fld
);

  localparam int CW = $clog2(SPACE_DEPTH + 1);
  localparam int IW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

  logic [7:0]    mem [SPACE_DEPTH];
  logic [7:0]    rdata;

  hfp_rec_t      pend;
  hfp_rec_t      pend_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] fptr;
  logic [CW-1:0] fptr_next;
  logic [CW-1:0] fnext;
  logic          rd_ok;
  logic          rd_ok_next;

  logic          out_valid;
  logic [2:0]    out_kind;
  logic [7:0]    out_byte;
  logic          out_last;
  logic          out_free;

  logic          emit;
  logic [2:0]    ekind;
  logic [7:0]    ebyte;
  logic          elast;
  logic          we;
  logic          re;
  logic [IW-1:0] raddr;
  logic          busy_next;

  assign fld.valid = out_valid;
  assign fld.kind = out_kind;
  assign fld.byte_out = out_byte;
  assign fld.last = out_last;
  assign out_free = !out_valid || fld.ready;
  assign fnext = fptr + CW'(1);

  always_comb begin
    pend_next = pend;
    cnt_next = cnt;
    fptr_next = fptr;
    rd_ok_next = rd_ok;
    emit = 1'b0;
    ekind = K_ERR;
    ebyte = '0;
    elast = 1'b0;
    we = 1'b0;
    re = 1'b0;
    raddr = fptr[IW-1:0];
    pop = 1'b0;

    if (pend.pair) begin
      if (out_free) begin
        emit = 1'b1;
        ekind = K_PAIR;
        elast = !(pend.flush || pend.e1 || pend.e2 || pend.hend || pend.err);
        pend_next.pair = 1'b0;
      end
    end else if (pend.clear) begin
      cnt_next = '0;
      pend_next.clear = 1'b0;
    end else if (pend.flush) begin
      if (!rd_ok) begin
        re = 1'b1;
        rd_ok_next = 1'b1;
      end else if (out_free) begin
        emit = 1'b1;
        ekind = {2'b00, pend.fkind};
        ebyte = rdata;
        elast = !((fnext < cnt) || pend.e1 || pend.e2 || pend.hend || pend.err);
        if (fnext < cnt) begin
          re = 1'b1;
          raddr = fnext[IW-1:0];
          fptr_next = fnext;
        end else begin
          pend_next.flush = 1'b0;
          fptr_next = '0;
          cnt_next = '0;
          rd_ok_next = 1'b0;
        end
      end
    end else if (pend.e1) begin
      if (out_free) begin
        emit = 1'b1;
        ekind = {2'b00, pend.k1};
        ebyte = pend.b1;
        elast = !(pend.e2 || pend.hend || pend.err);
        pend_next.e1 = 1'b0;
      end
    end else if (pend.e2) begin
      if (out_free) begin
        emit = 1'b1;
        ekind = {2'b00, pend.k2};
        ebyte = pend.b2;
        elast = !(pend.hend || pend.err);
        pend_next.e2 = 1'b0;
      end
    end else if (pend.hold) begin
      we = 1'b1;
      cnt_next = cnt + CW'(1);
      pend_next.hold = 1'b0;
    end else if (pend.hend) begin
      if (out_free) begin
        emit = 1'b1;
        ekind = K_END;
        elast = !pend.err;
        pend_next.hend = 1'b0;
      end
    end else if (pend.err) begin
      if (out_free) begin
        emit = 1'b1;
        ekind = K_ERR;
        elast = 1'b1;
        pend_next.err = 1'b0;
      end
    end

    busy_next = pend_next.pair || pend_next.clear || pend_next.flush || pend_next.e1 ||
                pend_next.e2 || pend_next.hold || pend_next.hend || pend_next.err;
    if (!busy_next && avail) begin
      pop = 1'b1;
      pend_next = rec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[cnt[IW-1:0]] <= pend.b2;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt <= '0;
      fptr <= '0;
      rd_ok <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= pend_next;
      cnt <= cnt_next;
      fptr <= fptr_next;
      rd_ok <= rd_ok_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (fld.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= ekind;
      out_byte <= ebyte;
      out_last <= elast;
    end
  end

endmodule

@@ rtl/core/header_field_stream_parser.sv @@
// Channel  Modport  Beat contents
// hdr      sink     op, byte_in
// fld      source   kind, byte_out, last
//
// Each accepted byte is classified combinationally and queued for the back end.
// The back end handles each result beat and each store write or clear as a step of its own;
// a flush of held whitespace first reads the store, then moves one byte per cycle
// while the output is not stalled.
// The input stalls only while the four-entry queue between the two parts is full.
// Reset is synchronous and empties the queue, the whitespace count and the output.
module header_field_stream_parser import hfp_pkg::*; #(
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  hfp_in_if.sink    hdr,
  hfp_out_if.source fld
);

  hfp_rec_t q_wdata;
  hfp_rec_t q_rdata;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_avail;

  hfp_front #(
    .SPACE_DEPTH(SPACE_DEPTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .hdr  (hdr),
    .rec  (q_wdata),
    .push (q_push),
    .full (q_full)
  );

  hfp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .avail (q_avail)
  );

  hfp_back #(
    .SPACE_DEPTH(SPACE_DEPTH)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .rec   (q_rdata),
    .avail (q_avail),
    .pop   (q_pop),
    .fld   (fld)
  );

endmodule

@@ rtl/core/hfp_checker.sv @@
`include "header_field_stream_parser_assert.svh"

module hfp_checker import hfp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] byte_out,
  input logic       last
);

  `HFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(byte_out) && $stable(last), "stalled result beat changed")
  `HFP_ASSERT_SAME(a_mark_zero, out_valid && (kind == K_PAIR || kind == K_END || kind == K_ERR), byte_out == 8'd0, "mark beat carries a nonzero byte")
  `HFP_ASSERT_SAME(a_stop_last, out_valid && (kind == K_END || kind == K_ERR), last, "headers end or error is not the final beat of its byte")
  `HFP_ASSERT_RESET(a_reset_idle, !out_valid && in_ready, "parser not idle after reset")

endmodule

bind header_field_stream_parser hfp_checker u_hfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (hdr.ready),
  .out_valid (fld.valid),
  .out_ready (fld.ready),
  .kind      (fld.kind),
  .byte_out  (fld.byte_out),
  .last      (fld.last)
);
